>>> hdl/ets_pkg.sv
// shared types, constants and helper functions for the epoch to calendar pipeline
// no dependencies; imported by every module of the block
`default_nettype none

package ets_pkg;

    // pipeline depth and per-stage load enables
    localparam int NUM_STAGES = 7;
    typedef logic [NUM_STAGES-1:0] stage_en_t;

    // field types
    typedef logic [15:0] day_count_t;   // whole days since the epoch, at most 49710
    typedef logic [16:0] sod_t;         // second of the day, 0..86399
    typedef logic [7:0]  year_off_t;    // years since 1970, 0..136
    typedef logic [8:0]  yday_t;        // day of the year, 0..365

    // time constants
    localparam logic [16:0] SECS_PER_DAY  = 17'd86400;
    localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
    localparam logic [5:0]  SECS_PER_MIN  = 6'd60;
    localparam logic [8:0]  DAYS_PER_YEAR = 9'd365;
    localparam logic [2:0]  DAYS_PER_WEEK = 3'd7;
    localparam logic [2:0]  EPOCH_WEEKDAY = 3'd4;   // thursday
    localparam logic [7:0]  EPOCH_YEAR_OFF = 8'd70; // 1970 - 1900
    localparam logic [7:0]  YEAR_OFF_2100 = 8'd130;
    localparam logic [7:0]  YEAR_OFF_2101 = 8'd131;

    // reciprocal multipliers for constant division
    // (x >> 7) / 675, floor estimate, may be one low
    localparam logic [25:0] DAY_RECIP        = 26'd50903316;
    localparam int          DAY_RECIP_SHIFT  = 35;
    // days / 365, exact for days < 2^16
    localparam logic [15:0] YEAR_RECIP       = 16'd45965;
    localparam int          YEAR_RECIP_SHIFT = 24;
    // x / 7, exact for x < 2^16
    localparam logic [16:0] WEEK_RECIP       = 17'd74899;
    localparam int          WEEK_RECIP_SHIFT = 19;
    // (sod >> 4) / 225, exact for sod < 86400
    localparam logic [12:0] HOUR_RECIP       = 13'd4661;
    localparam int          HOUR_RECIP_SHIFT = 20;
    // (rsec >> 2) / 15, exact for rsec < 3600
    localparam logic [10:0] MIN_RECIP        = 11'd1093;
    localparam int          MIN_RECIP_SHIFT  = 14;

    // days before the first of each month
    localparam yday_t CUM_NORMAL [0:11] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam yday_t CUM_LEAP [0:11] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

    // leap days between 1970 and the start of year 1970 + yo
    function automatic logic [5:0] leaps_before(input year_off_t yo);
        logic [8:0] inc;
        inc = {1'b0, yo} + 9'd1;
        leaps_before = inc[7:2] - ((yo >= YEAR_OFF_2101) ? 6'd1 : 6'd0);
    endfunction

    // gregorian leap rule over 1970..2106: only 2100 breaks the four-year rule
    function automatic logic is_leap(input year_off_t yo);
        is_leap = (yo[1:0] == 2'd2) && (yo != YEAR_OFF_2100);
    endfunction

endpackage

`default_nettype wire

>>> hdl/ets_day_split.sv
// stages 1 to 3: split the epoch seconds into whole days and second of day
// depends on ets_pkg
`default_nettype none

module ets_day_split (
    input  wire logic               aclk,
    input  wire ets_pkg::stage_en_t en,
    input  wire logic [31:0]        epoch_seconds,
    output ets_pkg::day_count_t     days,
    output ets_pkg::sod_t           sod
);
    import ets_pkg::*;

    logic [50:0] prod1;
    logic [32:0] prod2;
    logic [32:0] rem_full;

    logic [31:0] secs1_reg;
    day_count_t  q1_reg;
    logic [17:0] rem2_reg;
    day_count_t  q2_reg;
    day_count_t  days3_reg;
    sod_t        sod3_reg;

    // stage 1: quotient estimate by reciprocal multiply
    assign prod1 = 51'(epoch_seconds[31:7]) * 51'(DAY_RECIP);

    // stage 2: remainder of the estimate, below twice a day
    assign prod2    = 33'(q1_reg) * 33'(SECS_PER_DAY);
    assign rem_full = 33'(secs1_reg) - prod2;

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            secs1_reg <= epoch_seconds;
            q1_reg    <= prod1[DAY_RECIP_SHIFT +: 16];
        end
        if (en[1]) begin
            rem2_reg <= rem_full[17:0];
            q2_reg   <= q1_reg;
        end
        // stage 3: fix an estimate that came out one low
        if (en[2]) begin
            if (rem2_reg >= 18'(SECS_PER_DAY)) begin
                days3_reg <= q2_reg + 16'd1;
                sod3_reg  <= 17'(rem2_reg - 18'(SECS_PER_DAY));
            end else begin
                days3_reg <= q2_reg;
                sod3_reg  <= rem2_reg[16:0];
            end
        end
    end

    assign days = days3_reg;
    assign sod  = sod3_reg;

endmodule

`default_nettype wire

>>> hdl/ets_time_of_day.sv
// stages 4 to 7: hour, minute and second from the second of the day
// depends on ets_pkg
`default_nettype none

module ets_time_of_day (
    input  wire logic               aclk,
    input  wire ets_pkg::stage_en_t en,
    input  wire ets_pkg::sod_t      sod,
    output logic [4:0]              hour,
    output logic [5:0]              minute,
    output logic [5:0]              second
);
    import ets_pkg::*;

    logic [25:0] prod_h;
    logic [16:0] rsec_full;
    logic [20:0] prod_m;
    logic [11:0] sec_full;

    sod_t        sod4_reg;
    logic [4:0]  hour4_reg;
    logic [11:0] rsec5_reg;
    logic [4:0]  hour5_reg;
    logic [11:0] rsec6_reg;
    logic [5:0]  min6_reg;
    logic [4:0]  hour6_reg;
    logic [4:0]  hour7_reg;
    logic [5:0]  min7_reg;
    logic [5:0]  sec7_reg;

    // stage 4: hour by reciprocal multiply
    assign prod_h = 26'(sod[16:4]) * 26'(HOUR_RECIP);
    // stage 5: seconds within the hour
    assign rsec_full = sod4_reg - 17'(hour4_reg) * 17'(SECS_PER_HOUR);
    // stage 6: minute by reciprocal multiply
    assign prod_m = 21'(rsec5_reg[11:2]) * 21'(MIN_RECIP);
    // stage 7: seconds within the minute
    assign sec_full = rsec6_reg - 12'(min6_reg) * 12'(SECS_PER_MIN);

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            sod4_reg  <= sod;
            hour4_reg <= prod_h[HOUR_RECIP_SHIFT +: 5];
        end
        if (en[4]) begin
            rsec5_reg <= rsec_full[11:0];
            hour5_reg <= hour4_reg;
        end
        if (en[5]) begin
            rsec6_reg <= rsec5_reg;
            min6_reg  <= prod_m[MIN_RECIP_SHIFT +: 6];
            hour6_reg <= hour5_reg;
        end
        if (en[6]) begin
            sec7_reg  <= sec_full[5:0];
            min7_reg  <= min6_reg;
            hour7_reg <= hour6_reg;
        end
    end

    assign hour   = hour7_reg;
    assign minute = min7_reg;
    assign second = sec7_reg;

endmodule

`default_nettype wire

>>> hdl/ets_date.sv
// stages 4 to 7: year, day of year, month, day of month and weekday from the day count
// depends on ets_pkg
`default_nettype none

module ets_date (
    input  wire logic                aclk,
    input  wire ets_pkg::stage_en_t  en,
    input  wire ets_pkg::day_count_t days,
    output logic [7:0]               years_since_1900,
    output logic [3:0]               month,
    output logic [4:0]               day_of_month,
    output logic [2:0]               weekday,
    output logic [8:0]               day_of_year
);
    import ets_pkg::*;

    logic [31:0] prod_y;
    logic [16:0] wk_in;
    logic [33:0] prod_w;
    year_off_t   est_lo;
    day_count_t  dby_hi;
    day_count_t  dby_lo;
    logic [16:0] wk_in5;
    logic [16:0] wd_full;
    logic        step_back;
    year_off_t   yo_sel;
    day_count_t  dby_sel;
    day_count_t  yday_full;
    yday_t       tab [0:11];
    logic [3:0]  mon;
    yday_t       dom_full;

    year_off_t   est4_reg;
    logic [12:0] wq4_reg;
    day_count_t  days4_reg;
    year_off_t   est5_reg;
    day_count_t  dhi5_reg;
    day_count_t  dlo5_reg;
    day_count_t  days5_reg;
    logic [2:0]  wd5_reg;
    year_off_t   yo6_reg;
    yday_t       yday6_reg;
    logic        leap6_reg;
    logic [2:0]  wd6_reg;
    logic [7:0]  yso7_reg;
    logic [3:0]  mon7_reg;
    logic [4:0]  dom7_reg;
    logic [2:0]  wd7_reg;
    yday_t       yday7_reg;

    // stage 4: year estimate (never low, at most one high) and week quotient
    assign prod_y = 32'(days) * 32'(YEAR_RECIP);
    assign wk_in  = {1'b0, days} + 17'(EPOCH_WEEKDAY);
    assign prod_w = 34'(wk_in) * 34'(WEEK_RECIP);

    // stage 5: first day of the estimated year and of the one before, weekday
    assign est_lo  = est4_reg - 8'd1;
    assign dby_hi  = 16'(est4_reg) * 16'(DAYS_PER_YEAR) + 16'(leaps_before(est4_reg));
    assign dby_lo  = 16'(est_lo) * 16'(DAYS_PER_YEAR) + 16'(leaps_before(est_lo));
    assign wk_in5  = {1'b0, days4_reg} + 17'(EPOCH_WEEKDAY);
    assign wd_full = wk_in5 - 17'(wq4_reg) * 17'(DAYS_PER_WEEK);

    // stage 6: step back when the estimated year has not begun yet
    assign step_back = (est5_reg != 8'd0) && (dhi5_reg > days5_reg);
    assign yo_sel    = step_back ? (est5_reg - 8'd1) : est5_reg;
    assign dby_sel   = step_back ? dlo5_reg : dhi5_reg;
    assign yday_full = days5_reg - dby_sel;

    // stage 7: month from the cumulative-days table
    always_comb begin
        for (int i = 0; i < 12; i++) begin
            tab[i] = leap6_reg ? CUM_LEAP[i] : CUM_NORMAL[i];
        end
        mon = 4'd0;
        for (int i = 1; i < 12; i++) begin
            if (tab[i] <= yday6_reg) begin
                mon = mon + 4'd1;
            end
        end
    end

    assign dom_full = yday6_reg - tab[mon] + 9'd1;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            est4_reg  <= prod_y[YEAR_RECIP_SHIFT +: 8];
            wq4_reg   <= prod_w[WEEK_RECIP_SHIFT +: 13];
            days4_reg <= days;
        end
        if (en[4]) begin
            est5_reg  <= est4_reg;
            dhi5_reg  <= dby_hi;
            dlo5_reg  <= dby_lo;
            days5_reg <= days4_reg;
            wd5_reg   <= wd_full[2:0];
        end
        if (en[5]) begin
            yo6_reg   <= yo_sel;
            yday6_reg <= yday_full[8:0];
            leap6_reg <= is_leap(yo_sel);
            wd6_reg   <= wd5_reg;
        end
        if (en[6]) begin
            yso7_reg  <= yo6_reg + EPOCH_YEAR_OFF;
            mon7_reg  <= mon;
            dom7_reg  <= dom_full[4:0];
            wd7_reg   <= wd6_reg;
            yday7_reg <= yday6_reg;
        end
    end

    assign years_since_1900 = yso7_reg;
    assign month            = mon7_reg;
    assign day_of_month     = dom7_reg;
    assign weekday          = wd7_reg;
    assign day_of_year      = yday7_reg;

endmodule

`default_nettype wire

>>> hdl/epoch_seconds_to_calendar.sv
// epoch seconds to broken-down utc time, top level; uses ets_pkg and the three stage modules
// an accepted request passes through the 7 register stages to its result on the m_ side
// throughput: one request per cycle while m_ready is not held low; each of the 7 register stages holds one request
// a stalled stage holds its data, empty stages upstream of it still fill up
// aresetn (synchronous, active low) clears the stage valid bits; data registers are not reset
`default_nettype none

module epoch_seconds_to_calendar (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [31:0] s_epoch_seconds,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [5:0]       m_second,
    output logic [5:0]       m_minute,
    output logic [4:0]       m_hour,
    output logic [4:0]       m_day_of_month,
    output logic [3:0]       m_month,
    output logic [7:0]       m_years_since_1900,
    output logic [2:0]       m_weekday,
    output logic [8:0]       m_day_of_year
);
    import ets_pkg::*;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] vld_up;
    stage_en_t             stage_en;
    day_count_t            days;
    sod_t                  sod;

    // a stage loads when it is empty or the stage after it moves on
    always_comb begin
        stage_en[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || m_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    // valid bits travel with the data
    assign vld_up = {vld_reg[NUM_STAGES-2:0], s_valid};

    always_comb begin
        for (int i = 0; i < NUM_STAGES; i++) begin
            vld_next[i] = stage_en[i] ? vld_up[i] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[NUM_STAGES-1];

    // days and second of day
    ets_day_split u_day_split (
        .aclk          (aclk),
        .en            (stage_en),
        .epoch_seconds (s_epoch_seconds),
        .days          (days),
        .sod           (sod)
    );

    // clock fields
    ets_time_of_day u_time_of_day (
        .aclk   (aclk),
        .en     (stage_en),
        .sod    (sod),
        .hour   (m_hour),
        .minute (m_minute),
        .second (m_second)
    );

    // calendar fields
    ets_date u_date (
        .aclk             (aclk),
        .en               (stage_en),
        .days             (days),
        .years_since_1900 (m_years_since_1900),
        .month            (m_month),
        .day_of_month     (m_day_of_month),
        .weekday          (m_weekday),
        .day_of_year      (m_day_of_year)
    );

    // checks
    a_sod_range: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[2] |-> (sod < SECS_PER_DAY))
        else $error("second of day out of range after day split");

    a_clock_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_hour <= 5'd23 && m_minute <= 6'd59 && m_second <= 6'd59))
        else $error("clock field out of range");

    a_date_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_month <= 4'd11 && m_day_of_month != 5'd0 && m_weekday <= 3'd6
                     && m_day_of_year <= 9'd365))
        else $error("date field out of range");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (vld_reg == '1 && !m_ready) |-> !s_ready)
        else $error("request accepted into a full pipeline");

endmodule

`default_nettype wire

>>> verif/epoch_seconds_to_calendar_checker.sv
// checker for the epoch to calendar block: watches the request and result channels,
// predicts each broken-down utc time and compares it with the block's result
// standalone; no dependencies beyond the port list of epoch_seconds_to_calendar
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [31:0] s_epoch_seconds,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [5:0]  m_second,
    input  logic [5:0]  m_minute,
    input  logic [4:0]  m_hour,
    input  logic [4:0]  m_day_of_month,
    input  logic [3:0]  m_month,
    input  logic [7:0]  m_years_since_1900,
    input  logic [2:0]  m_weekday,
    input  logic [8:0]  m_day_of_year,
    output int          mismatch_count,
    output int          dates_in_flight
);

    // broken-down time at the widths of the result ports
    typedef struct packed {
        logic [31:0] epoch;
        logic [5:0]  second;
        logic [5:0]  minute;
        logic [4:0]  hour;
        logic [4:0]  mday;
        logic [3:0]  month;
        logic [7:0]  year_off;
        logic [2:0]  wday;
        logic [8:0]  yday;
    } civil_time_t;

    localparam int unsigned SECS_IN_DAY = 86400;
    localparam int unsigned FIRST_YEAR  = 1970;
    localparam int unsigned THURSDAY    = 4;

    // month lengths of a normal year, february fixed up for leap years
    localparam int unsigned MONTH_DAYS [0:11] = '{
        31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31
    };

    civil_time_t expected_dates [$];

    initial mismatch_count = 0;
    assign dates_in_flight = expected_dates.size();

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // walk the calendar forward from the epoch one year and one month at a time
    function automatic civil_time_t to_civil(input logic [31:0] epoch);
        int unsigned day_num;
        int unsigned sec_of_day;
        int unsigned yr;
        int unsigned rem;
        int unsigned mon;
        int unsigned mon_len;
        civil_time_t t;
        day_num    = epoch / SECS_IN_DAY;
        sec_of_day = epoch % SECS_IN_DAY;
        yr  = FIRST_YEAR;
        rem = day_num;
        while (rem >= (leap_year(yr) ? 366 : 365)) begin
            rem = rem - (leap_year(yr) ? 366 : 365);
            yr++;
        end
        t.yday = 9'(rem);
        mon = 0;
        mon_len = MONTH_DAYS[0];
        while (mon < 11 && rem >= mon_len) begin
            rem = rem - mon_len;
            mon++;
            mon_len = MONTH_DAYS[mon] + ((mon == 1 && leap_year(yr)) ? 1 : 0);
        end
        t.epoch    = epoch;
        t.second   = 6'(sec_of_day % 60);
        t.minute   = 6'((sec_of_day / 60) % 60);
        t.hour     = 5'(sec_of_day / 3600);
        t.mday     = 5'(rem + 1);
        t.month    = 4'(mon);
        t.year_off = 8'(yr - 1900);
        t.wday     = 3'((day_num + THURSDAY) % 7);
        return t;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] epoch,
                                   input int got, input int want);
        mismatch_count++;
        $display("[%0t] mismatch on %s for epoch %0d: got %0d, expected %0d",
                 $realtime, what, epoch, got, want);
    endtask

    task automatic check_field(input string what, input logic [31:0] epoch,
                               input int got, input int want);
        if (got != want)
            report_mismatch(what, epoch, got, want);
    endtask

    // result side first, then queue the prediction for the accepted request
    always @(posedge aclk) begin
        civil_time_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_dates.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, int'(m_day_of_year), 0);
                end else begin
                    want = expected_dates.pop_front();
                    check_field("second", want.epoch, int'(m_second), int'(want.second));
                    check_field("minute", want.epoch, int'(m_minute), int'(want.minute));
                    check_field("hour", want.epoch, int'(m_hour), int'(want.hour));
                    check_field("day_of_month", want.epoch, int'(m_day_of_month),
                                int'(want.mday));
                    check_field("month", want.epoch, int'(m_month), int'(want.month));
                    check_field("years_since_1900", want.epoch, int'(m_years_since_1900),
                                int'(want.year_off));
                    check_field("weekday", want.epoch, int'(m_weekday), int'(want.wday));
                    check_field("day_of_year", want.epoch, int'(m_day_of_year),
                                int'(want.yday));
                end
            end
            if (s_valid && s_ready)
                expected_dates.push_back(to_civil(s_epoch_seconds));
        end
    end

endmodule

>>> verif/epoch_seconds_to_calendar_tb.sv
// testbench top for epoch_seconds_to_calendar: clock, reset, request stimulus
// and result-side stalls; depends on the block and epoch_seconds_to_calendar_checker
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;

    localparam int RANDOM_REQUESTS = 1600;
    localparam int MAX_IDLE        = 13;
    localparam int DRAIN_CYCLES    = 30;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_epoch_seconds = 32'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [5:0]  m_second;
    logic [5:0]  m_minute;
    logic [4:0]  m_hour;
    logic [4:0]  m_day_of_month;
    logic [3:0]  m_month;
    logic [7:0]  m_years_since_1900;
    logic [2:0]  m_weekday;
    logic [8:0]  m_day_of_year;

    int mismatch_count;
    int dates_in_flight;
    bit src_burst  = 1'b0;
    bit sink_burst = 1'b0;
    int sink_hold  = 0;

    epoch_seconds_to_calendar dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second           (m_second),
        .m_minute           (m_minute),
        .m_hour             (m_hour),
        .m_day_of_month     (m_day_of_month),
        .m_month            (m_month),
        .m_years_since_1900 (m_years_since_1900),
        .m_weekday          (m_weekday),
        .m_day_of_year      (m_day_of_year)
    );

    epoch_seconds_to_calendar_checker checker_i (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_epoch_seconds    (s_epoch_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_second           (m_second),
        .m_minute           (m_minute),
        .m_hour             (m_hour),
        .m_day_of_month     (m_day_of_month),
        .m_month            (m_month),
        .m_years_since_1900 (m_years_since_1900),
        .m_weekday          (m_weekday),
        .m_day_of_year      (m_day_of_year),
        .mismatch_count     (mismatch_count),
        .dates_in_flight    (dates_in_flight)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hard stop well past the slowest legal run
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // result side: after each result, a random stall up to MAX_IDLE, or none while in a burst
    always @(posedge aclk) begin
        int stall;
        if (!aresetn) begin
            m_ready   <= 1'b0;
            sink_hold <= 0;
        end else if (m_valid && m_ready) begin
            if ($urandom_range(0, 39) == 0)
                sink_burst <= !sink_burst;
            stall = sink_burst ? 0 : $urandom_range(0, MAX_IDLE);
            if (stall != 0) begin
                m_ready   <= 1'b0;
                sink_hold <= stall;
            end
        end else if (!m_ready) begin
            if (sink_hold <= 1) begin
                m_ready   <= 1'b1;
                sink_hold <= 0;
            end else begin
                sink_hold <= sink_hold - 1;
            end
        end
    end

    function automatic bit leap_year(input int unsigned yr);
        return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
    endfunction

    // seconds at 00:00:00 on january 1 of a year
    function automatic longint jan1_epoch(input int unsigned yr);
        longint days;
        days = 0;
        for (int unsigned y = 1970; y < yr; y++)
            days += leap_year(y) ? 366 : 365;
        return days * 86400;
    endfunction

    // one request: optional idle gap, then hold valid until accepted
    task automatic send_request(input logic [31:0] epoch);
        int gap;
        if ($urandom_range(0, 39) == 0)
            src_burst = !src_burst;
        gap = src_burst ? 0 : $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid         <= 1'b1;
        s_epoch_seconds <= epoch;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    // random request aimed at year, month and day boundaries most of the time
    function automatic logic [31:0] pick_epoch();
        int     kind;
        longint val;
        kind = $urandom_range(0, 99);
        if (kind < 30) begin
            val = $urandom;
        end else if (kind < 60) begin
            val = jan1_epoch($urandom_range(1971, 2106)) - 172800
                + $urandom_range(0, 345600);
        end else if (kind < 80) begin
            val = longint'($urandom_range(0, 49709)) * 86400 + $urandom_range(0, 7200)
                - 3600;
        end else if (kind < 95) begin
            val = jan1_epoch($urandom_range(1970, 2105))
                + longint'($urandom_range(57, 60)) * 86400 + $urandom_range(0, 86399);
        end else begin
            val = 64'hFFFF_FFFF - $urandom_range(0, 200000);
        end
        if (val < 0)
            val = 0;
        if (val > 64'hFFFF_FFFF)
            val = 64'hFFFF_FFFF;
        return val[31:0];
    endfunction

    logic [31:0] directed_epochs [$] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd31535999,   32'd31536000,   32'd94608000,   32'd946684799,
        32'd946684800,  32'd951782400,  32'd951868800,  32'd4102444799,
        32'd4102444800, 32'd4107456000, 32'd4107542400, 32'd4133980799,
        32'd4133980800, 32'h7FFF_FFFF,  32'h8000_0000,  32'hAAAA_AAAA,
        32'hFFFF_FFFF
    };

    // stimulus and verdict
    initial begin
        int spins;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_epochs[i])
            send_request(directed_epochs[i]);
        repeat (RANDOM_REQUESTS)
            send_request(pick_epoch());
        s_valid <= 1'b0;

        spins = 0;
        while (dates_in_flight != 0 && spins < 100000) begin
            @(posedge aclk);
            spins++;
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && dates_in_flight == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
hdl/ets_pkg.sv
hdl/ets_day_split.sv
hdl/ets_time_of_day.sv
hdl/ets_date.sv
hdl/epoch_seconds_to_calendar.sv
verif/epoch_seconds_to_calendar_checker.sv
verif/epoch_seconds_to_calendar_tb.sv
